@@ src/dssc_pkg.sv @@
// Package with the word types and constants of the decayed-score slot cache.
`timescale 1ns / 1ps
package dssc_pkg;
	localparam int KEY_W = 32;
	localparam int SLOT_W = 4;
	localparam int SCORE_W = 32;
	localparam int CAP_W = 5;
	localparam int DECAY_W = 17;
	localparam logic [SCORE_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [DECAY_W-1:0] DEFAULT_DECAY = 17'd64225;
	localparam logic [DECAY_W-1:0] UNITY_DECAY = 17'd65536;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_END_STEP = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_DECAY = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic hit;
		logic exhausted;
		logic evicted_valid;
		logic [KEY_W-1:0] evicted_key;
		logic found;
	} res_t;
endpackage

@@ src/decayed_score_slot_cache_top.sv @@
// Top level of the decayed-score slot cache: entry memory and sequencer.
`timescale 1ns / 1ps
// The cache maps keys to storage slots. A command word is taken when start is
// high and busy is low; exactly one result word follows, shown for one cycle
// with done high, and the receiver cannot hold it off. Entries live in one
// synchronous memory with a registered read, so every command but a clear
// walks the dense entry list one entry per pass step. An acquire runs a key
// search pass, then on a miss without free slot a victim search pass, then
// the move of the last entry and the append; a hit on a dense entry ends the
// search there. An end step does per entry one read, one registered decay
// multiply and one write back. A lookup walks at most the whole list, and a
// clear goes straight to the result. Busy stays high until the cycle before
// done. There is no clearing pass after reset; the entry count is zero.
module decayed_score_slot_cache_top
	import dssc_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	output logic busy,
	output logic done,
	output res_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [DECAY_W-1:0] cfg_data
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SLOT_W-1:0] slot;
		logic [SCORE_W-1:0] score;
		logic [31:0] last;
		logic prot;
	} ent_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_FIND_CHK, S_VIC, S_VIC_CHK, S_MOVE_RD, S_MOVE_WR,
		S_APPEND, S_DEC_RD, S_DEC_MUL, S_DEC_WR, S_DONE
	} state_t;

	state_t state_q;
	ent_t mem [SLOTS];
	ent_t rd_q;
	logic [IW-1:0] raddr, waddr;
	logic re, we;
	ent_t wdata;

	logic [CAP_W-1:0] cap_q;
	logic [DECAY_W-1:0] decay_q;
	logic [CW-1:0] count_q, nfree_q;
	logic [31:0] step_q;
	cmd_t cmd_q;
	logic [CW-1:0] idx_q;
	logic best_v_q;
	logic [IW-1:0] best_q;
	ent_t best_e_q;
	logic [SCORE_W+DECAY_W-1:0] prod_q;
	res_t res_q;
	logic done_q;
	logic [CW-1:0] cap_eff;
	logic [DECAY_W-1:0] dec_eff;
	logic [SCORE_W-1:0] sat_score;
	logic better;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// Capacity above SLOTS acts as SLOTS; zero or over-unity decay as default.
	always_comb begin
		if ({{(32-CAP_W){1'b0}}, cap_q} > 32'(SLOTS)) cap_eff = CW'(SLOTS);
		else cap_eff = CW'(cap_q);
		if (decay_q == '0 || decay_q > UNITY_DECAY) dec_eff = DEFAULT_DECAY;
		else dec_eff = decay_q;
		sat_score = (rd_q.score > ~ONE_Q16) ? '1 : rd_q.score + ONE_Q16;
		better = !best_v_q || rd_q.score < best_e_q.score ||
			(rd_q.score == best_e_q.score && rd_q.last < best_e_q.last);
	end

	// Port drive per state: reads at idx_q or the last entry, writes as needed.
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		raddr = idx_q[IW-1:0];
		waddr = idx_q[IW-1:0];
		wdata = rd_q;
		case (state_q)
			S_FIND, S_VIC, S_DEC_RD: re = 1'b1;
			S_FIND_CHK: begin
				if (idx_q != '0 && cmd_q.op == OP_ACQUIRE && rd_q.key == cmd_q.key &&
						cap_eff != '0) begin
					we = 1'b1;
					waddr = idx_q[IW-1:0] - IW'(1);
					wdata.score = sat_score;
					wdata.last = step_q;
					wdata.prot = 1'b1;
				end
			end
			S_MOVE_RD: begin
				re = 1'b1;
				raddr = IW'(count_q - CW'(1));
			end
			S_MOVE_WR: begin
				we = 1'b1;
				waddr = best_q;
			end
			S_APPEND: begin
				we = 1'b1;
				waddr = IW'(count_q);
				wdata.key = cmd_q.key;
				wdata.slot = (best_v_q) ? best_e_q.slot : SLOT_W'(nfree_q);
				wdata.score = ONE_Q16;
				wdata.last = step_q;
				wdata.prot = 1'b1;
			end
			S_DEC_WR: begin
				we = 1'b1;
				waddr = IW'(idx_q - CW'(1));
				wdata.score = prod_q[16 +: SCORE_W];
				wdata.prot = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= CAP_RESET;
			decay_q <= DEFAULT_DECAY;
			count_q <= '0;
			nfree_q <= '0;
			step_q <= '0;
			done_q <= 1'b0;
			idx_q <= '0;
			best_v_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_CAPACITY) cap_q <= cfg_data[CAP_W-1:0];
				else decay_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						idx_q <= '0;
						best_v_q <= 1'b0;
						res_q <= '0;
						case (cmd.op)
							OP_CLEAR: begin
								count_q <= '0;
								nfree_q <= '0;
								state_q <= S_DONE;
							end
							OP_END_STEP: state_q <= (count_q == '0) ? S_DONE : S_DEC_RD;
							default: state_q <= (count_q == '0) ? S_FIND_CHK : S_FIND;
						endcase
						if (cmd.op == OP_END_STEP) step_q <= step_q + 32'd1;
					end
				end
				S_FIND: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_FIND_CHK;
				end
				S_FIND_CHK: begin
					if (idx_q != '0 && rd_q.key == cmd_q.key) begin
						if (cmd_q.op == OP_LOOKUP) begin
							res_q.slot <= rd_q.slot;
							res_q.found <= 1'b1;
						end else if (cap_eff == '0) begin
							res_q.exhausted <= 1'b1;
						end else begin
							res_q.slot <= rd_q.slot;
							res_q.hit <= 1'b1;
						end
						state_q <= S_DONE;
					end else if (idx_q < count_q) begin
						state_q <= S_FIND;
					end else if (cmd_q.op == OP_LOOKUP) begin
						state_q <= S_DONE;
					end else if (cap_eff == '0) begin
						res_q.exhausted <= 1'b1;
						state_q <= S_DONE;
					end else if (nfree_q < cap_eff && count_q < CW'(SLOTS)) begin
						state_q <= S_APPEND;
					end else begin
						idx_q <= '0;
						state_q <= S_VIC;
					end
				end
				S_VIC: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_VIC_CHK;
				end
				S_VIC_CHK: begin
					if (!rd_q.prot && better) begin
						best_v_q <= 1'b1;
						best_e_q <= rd_q;
						best_q <= IW'(idx_q - CW'(1));
					end
					if (idx_q < count_q) state_q <= S_VIC;
					else if (!best_v_q && rd_q.prot) begin
						res_q.exhausted <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_MOVE_RD;
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					count_q <= count_q - CW'(1);
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					count_q <= count_q + CW'(1);
					if (best_v_q) begin
						res_q.slot <= best_e_q.slot;
						res_q.evicted_valid <= 1'b1;
						res_q.evicted_key <= best_e_q.key;
					end else begin
						res_q.slot <= SLOT_W'(nfree_q);
						nfree_q <= nfree_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DEC_RD: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_DEC_MUL;
				end
				S_DEC_MUL: begin
					prod_q <= rd_q.score * dec_eff;
					state_q <= S_DEC_WR;
				end
				S_DEC_WR: state_q <= (idx_q < count_q) ? S_DEC_RD : S_DONE;
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// When the victim is the last entry, the move rewrites it in place and the
	// append then overwrites the same address, so no special case is needed.
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS)) else $error("entry count beyond slots");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result shown twice");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.hit && result.evicted_valid)) else $error("hit and evict");
	a_ev_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.evicted_valid |-> result.evicted_key == '0)
		else $error("stale evicted key");
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the decayed-score slot cache top level.
`timescale 1ns / 1ps
// The testbench sends command words through the start/busy handshake and keeps its own
// model of the cache: a dense entry list with keys, slots, UQ16.16 scores, last-use steps
// and protection flags. Each command word yields one expected result word. A checker
// process compares every result word flagged by done with the oldest expected word.
// Stimulus starts with directed tests of the special cases. Random phases then run
// acquire-heavy traffic over small key pools under changing capacity and decay settings.
module testbench;
	import dssc_pkg::*;

	localparam int NSLOT = 16;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;
	logic cfg_we;
	logic cfg_index;
	logic [DECAY_W-1:0] cfg_data;

	decayed_score_slot_cache_top #(.SLOTS(NSLOT)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
		.result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Model state of the cache.
	logic [KEY_W-1:0] m_key [NSLOT];
	logic [SLOT_W-1:0] m_slot [NSLOT];
	logic [SCORE_W-1:0] m_score [NSLOT];
	logic [31:0] m_last [NSLOT];
	logic m_prot [NSLOT];
	int unsigned m_count;
	int unsigned m_next_free;
	logic [31:0] m_step;
	logic [CAP_W-1:0] m_capacity;
	logic [DECAY_W-1:0] m_decay;

	res_t pending_results[$];
	int unsigned mismatches;
	int unsigned words_checked;
	int unsigned words_sent;
	int unsigned evictions_seen;
	int unsigned exhausted_seen;
	int unsigned burst_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Timeout waiting for the cache to finish.");
		$display("** decayed_score_slot_cache_top: FAILED **");
		$finish;
	end

	function automatic int find_entry(logic [KEY_W-1:0] k);
		for (int i = 0; i < int'(m_count); i++)
			if (m_key[i] == k)
				return i;
		return -1;
	endfunction

	// The victim is the unprotected entry with the lowest score. Ties go to the
	// oldest last use, then to the entry first in the dense order.
	function automatic int pick_victim();
		int best;
		best = -1;
		for (int i = 0; i < int'(m_count); i++) begin
			if (m_prot[i])
				continue;
			if (best < 0 || m_score[i] < m_score[best] ||
					(m_score[i] == m_score[best] && m_last[i] < m_last[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic res_t predict_cache(cmd_t c);
		res_t r;
		int pos;
		int v;
		int unsigned cap;
		int unsigned last;
		logic [SLOT_W-1:0] ns;
		logic [DECAY_W-1:0] d;
		logic [63:0] prod;
		r = '0;
		case (c.op)
			OP_ACQUIRE: begin
				cap = (m_capacity > NSLOT) ? NSLOT : m_capacity;
				pos = find_entry(c.key);
				if (cap == 0) begin
					r.exhausted = 1'b1;
				end else if (pos >= 0) begin
					m_score[pos] = (m_score[pos] > 32'hFFFF_FFFF - ONE_Q16) ? 32'hFFFF_FFFF
						: m_score[pos] + ONE_Q16;
					m_last[pos] = m_step;
					m_prot[pos] = 1'b1;
					r.slot = m_slot[pos];
					r.hit = 1'b1;
				end else begin
					v = 0;
					if (m_next_free < cap && m_count < NSLOT) begin
						ns = m_next_free[SLOT_W-1:0];
						m_next_free++;
					end else begin
						v = pick_victim();
						if (v >= 0) begin
							last = m_count - 1;
							r.evicted_valid = 1'b1;
							r.evicted_key = m_key[v];
							ns = m_slot[v];
							m_key[v] = m_key[last];
							m_slot[v] = m_slot[last];
							m_score[v] = m_score[last];
							m_last[v] = m_last[last];
							m_prot[v] = m_prot[last];
							m_count = last;
						end
					end
					if (v < 0) begin
						r.exhausted = 1'b1;
					end else begin
						m_key[m_count] = c.key;
						m_slot[m_count] = ns;
						m_score[m_count] = ONE_Q16;
						m_last[m_count] = m_step;
						m_prot[m_count] = 1'b1;
						m_count++;
						r.slot = ns;
					end
				end
			end
			OP_END_STEP: begin
				d = (m_decay == 0 || m_decay > UNITY_DECAY) ? DEFAULT_DECAY : m_decay;
				for (int i = 0; i < int'(m_count); i++) begin
					prod = 64'(m_score[i]) * 64'(d);
					m_score[i] = prod[47:16];
					m_prot[i] = 1'b0;
				end
				m_step = m_step + 1;
			end
			OP_LOOKUP: begin
				pos = find_entry(c.key);
				if (pos >= 0) begin
					r.slot = m_slot[pos];
					r.found = 1'b1;
				end
			end
			default: begin
				m_count = 0;
				m_next_free = 0;
			end
		endcase
		return r;
	endfunction

	// The checker compares each result word with the oldest expected word.
	always @(posedge clk) begin
		res_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %p", result);
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (result.evicted_valid === 1'b1)
					evictions_seen++;
				if (result.exhausted === 1'b1)
					exhausted_seen++;
				if (result.slot !== want.slot || result.hit !== want.hit ||
						result.exhausted !== want.exhausted ||
						result.evicted_valid !== want.evicted_valid ||
						result.evicted_key !== want.evicted_key ||
						result.found !== want.found) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch at %0t: expected %p, got %p", $realtime,
							want, result);
				end
			end
		end
	end

	// Sends one command word. The sender works in bursts with random gaps between them;
	// start stays high from one word of a burst to the next.
	task automatic send_cmd(logic [1:0] op, logic [KEY_W-1:0] k);
		cmd_t c;
		res_t exp_word;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		c.op = op;
		c.key = k;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		exp_word = predict_cache(c);
		pending_results = {pending_results, exp_word};
		words_sent++;
	endtask

	// Waits until every expected word has come, then lets the block settle.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [DECAY_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CAPACITY)
			m_capacity = val[CAP_W-1:0];
		else
			m_decay = val;
	endtask

	// Fills the cache, hits entries, then forces evictions and exhaustion.
	task automatic test_fill_and_evict();
		send_cmd(OP_LOOKUP, 32'hFFFF_FFFF);
		for (int i = 0; i < NSLOT; i++)
			send_cmd(OP_ACQUIRE, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h100 + i);
		send_cmd(OP_ACQUIRE, 32'h0);
		send_cmd(OP_ACQUIRE, 32'hAAAA_5555);
		send_cmd(OP_END_STEP, 32'h0);
		send_cmd(OP_ACQUIRE, 32'h0);
		send_cmd(OP_ACQUIRE, 32'h5555_AAAA);
		send_cmd(OP_LOOKUP, 32'h0);
		send_cmd(OP_LOOKUP, 32'h102);
		send_cmd(OP_CLEAR, 32'hFFFF_FFFF);
		send_cmd(OP_LOOKUP, 32'h0);
	endtask

	// Zero capacity never serves; capacity above the slot count acts as full size.
	task automatic test_capacity_extremes();
		write_cfg(CFG_CAPACITY, 17'd0);
		send_cmd(OP_ACQUIRE, 32'h1234);
		write_cfg(CFG_CAPACITY, 17'h1FFFF);
		for (int i = 0; i < 3; i++)
			send_cmd(OP_ACQUIRE, 32'h77 + i);
		write_cfg(CFG_CAPACITY, 17'd1);
		send_cmd(OP_ACQUIRE, 32'h99);
		send_cmd(OP_END_STEP, 32'h0);
		send_cmd(OP_ACQUIRE, 32'h98);
	endtask

	// Repeated hits without an end step raise one score; end steps use decay 0 and 1.
	task automatic test_score_saturation();
		write_cfg(CFG_DECAY, UNITY_DECAY);
		write_cfg(CFG_CAPACITY, 17'd4);
		send_cmd(OP_CLEAR, 32'h0);
		repeat (8) send_cmd(OP_ACQUIRE, 32'hC0DE);
		write_cfg(CFG_DECAY, 17'd0);
		send_cmd(OP_END_STEP, 32'h0);
		write_cfg(CFG_DECAY, 17'd1);
		send_cmd(OP_END_STEP, 32'h0);
	endtask

	// Random phases: mostly acquires over small key pools, with end steps and rare clears.
	task automatic test_random_traffic(int unsigned n_items);
		logic [KEY_W-1:0] pool [24];
		int unsigned pick;
		int unsigned pool_size;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: write_cfg(CFG_CAPACITY, 17'($urandom_range(1, 16)));
				1: write_cfg(CFG_CAPACITY, 17'($urandom_range(0, 31)));
				2: write_cfg(CFG_CAPACITY, 17'd16);
				default: write_cfg(CFG_CAPACITY, 17'($urandom_range(2, 6)));
			endcase
			case (phase % 3)
				0: write_cfg(CFG_DECAY, 17'($urandom_range(1, 65536)));
				1: write_cfg(CFG_DECAY, 17'($urandom_range(0, 131071)));
				default: write_cfg(CFG_DECAY, 17'($urandom_range(60000, 65536)));
			endcase
			pool_size = $urandom_range(6, 24);
			for (int i = 0; i < 24; i++)
				pool[i] = $urandom();
			for (int unsigned n = 0; n < n_items / 8; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					send_cmd(OP_ACQUIRE, pool[$urandom_range(0, pool_size - 1)]);
				else if (pick < 80)
					send_cmd(OP_END_STEP, $urandom());
				else if (pick < 97)
					send_cmd(OP_LOOKUP, ($urandom_range(0, 3) == 0) ? $urandom()
						: pool[$urandom_range(0, pool_size - 1)]);
				else
					send_cmd(OP_CLEAR, $urandom());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;
		m_count = 0;
		m_next_free = 0;
		m_step = '0;
		m_capacity = CAP_RESET;
		m_decay = DEFAULT_DECAY;
		mismatches = 0;
		words_checked = 0;
		words_sent = 0;
		evictions_seen = 0;
		exhausted_seen = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_evict();
		test_capacity_extremes();
		test_score_saturation();
		test_random_traffic(1400);
		wait_idle();
		$display("Sent %0d command words and checked %0d result words.", words_sent,
			words_checked);
		$display("Saw %0d evictions and %0d exhausted acquires.", evictions_seen,
			exhausted_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** decayed_score_slot_cache_top: PASSED **");
		end else begin
			$display("Mismatches: %0d", mismatches);
			$display("** decayed_score_slot_cache_top: FAILED **");
		end
		$finish;
	end
endmodule

@@ decayed_score_slot_cache_top.f @@
src/dssc_pkg.sv
src/decayed_score_slot_cache_top.sv
dv/testbench.sv
